[sv/rlpk_pkg.sv]
// Shared types, constants and the arctangent table for the rigid link point kinematics block.
package rlpk_pkg;

  localparam int CW = 34;

  localparam logic signed [CW-1:0] PI_Q28      = 34'sd843314857;
  localparam logic signed [CW-1:0] HALF_PI_Q28 = 34'sd421657428;
  localparam logic signed [CW-1:0] TWO_PI_Q28  = 34'sd1686629713;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CW-1:0] Z_LIMIT     = 34'sd1686629712;

  typedef struct packed {
    logic signed [31:0] base_pos_x;
    logic signed [31:0] base_pos_y;
    logic signed [31:0] base_vel_x;
    logic signed [31:0] base_vel_y;
    logic signed [31:0] base_acc_x;
    logic signed [31:0] base_acc_y;
    logic signed [31:0] link_angle;
    logic signed [31:0] link_omega;
    logic signed [31:0] link_alpha;
    logic [30:0]        link_length;
  } in_t;

  typedef struct packed {
    logic signed [31:0] end_pos_x;
    logic signed [31:0] end_pos_y;
    logic signed [31:0] end_vel_x;
    logic signed [31:0] end_vel_y;
    logic signed [31:0] end_acc_x;
    logic signed [31:0] end_acc_y;
    logic               saturated;
  } out_t;

  function automatic logic [31:0] atan_val(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F;
      5'd25: r = 32'h0000001F;
      5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000008;
      5'd28: r = 32'h00000004;
      5'd29: r = 32'h00000002;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

[sv/rigid_link_point_kinematics.sv]
// Top level of the planar rigid link point kinematics pipeline.
// Usage:
//   in_valid/in_ready/in_data carry one transaction per link: base point position,
//   velocity and acceleration, link angle (Q4.28), angular velocity, angular
//   acceleration and length. out_valid/out_ready/out_data return the end point
//   position, velocity and acceleration in Q16.16, clipped to 32 bits, and a
//   saturated flag set when any clip took place.
//   Throughput is one transaction per cycle while out_ready is high. Stages:
//   one reduction stage, CORDIC_STEPS rotation stages and a sign stage in the
//   CORDIC pipeline, then three multiply stages and the output register.
//   Each stage advances when its successor is empty or advancing, so a stalled
//   receiver holds the output register and bubbles upstream still fill.
//   in_ready drops only when every stage holds a transaction.
//   Synchronous reset clears all valid bits; no transaction survives it.
module rigid_link_point_kinematics import rlpk_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int SW = 56;
  localparam int PW = 36;
  localparam int TW = 52;

  logic                 cv;
  logic signed [CW-1:0] cc, cs;
  in_t                  cp;
  logic rdy_a, rdy_b, rdy_c, rdy_d;

  rlpk_cordic #(.Steps(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(cv), .out_ready(rdy_a), .out_cos(cc), .out_sin(cs), .out_data(cp)
  );

  logic va_r, vb_r, vc_r, out_valid_r;

  logic signed [PW-1:0] a_px_r, a_py_r, a_sw_r, a_cw_r, a_sa_r, a_ca_r;
  in_t                  a_pl_r;
  logic signed [SW-1:0] b_r0_r, b_r1_r;
  logic signed [TW-1:0] b_tvx_r, b_tvy_r, b_tax_r, b_tay_r, b_cww_r, b_sww_r;
  in_t                  b_pl_r;
  logic signed [SW-1:0] c_r0_r, c_r1_r, c_r2_r, c_r3_r, c_r4_r, c_r5_r;
  logic signed [47:0]   c_tcx_r, c_tsx_r;
  logic                 c_sat_r;
  out_t                 out_data_r;

  assign rdy_d = !out_valid_r || out_ready;
  assign rdy_c = !vc_r || rdy_d;
  assign rdy_b = !vb_r || rdy_c;
  assign rdy_a = !va_r || rdy_b;

  function automatic logic [32:0] clip32(input logic signed [SW-1:0] v);
    logic [32:0] r;
    if (v[SW-1:31] != {(SW-31){v[SW-1]}}) begin
      r = {1'b1, v[SW-1] ? 32'h80000000 : 32'h7FFFFFFF};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= cv;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
      if (rdy_d) out_valid_r <= vc_r;
    end
  end

  logic signed [31:0]   a_len;
  logic signed [CW+31:0] m_px, m_py, m_sw, m_cw, m_sa, m_ca;
  assign a_len = $signed({1'b0, cp.link_length});
  assign m_px  = 66'(cc * a_len);
  assign m_py  = 66'(cs * a_len);
  assign m_sw  = 66'(cs * cp.link_omega);
  assign m_cw  = 66'(cc * cp.link_omega);
  assign m_sa  = 66'(cs * cp.link_alpha);
  assign m_ca  = 66'(cc * cp.link_alpha);

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a_px_r <= PW'(m_px >>> 30);
      a_py_r <= PW'(m_py >>> 30);
      a_sw_r <= PW'(m_sw >>> 30);
      a_cw_r <= PW'(m_cw >>> 30);
      a_sa_r <= PW'(m_sa >>> 30);
      a_ca_r <= PW'(m_ca >>> 30);
      a_pl_r <= cp;
    end
  end

  logic signed [31:0]   b_len;
  logic signed [PW+31:0] m_tvx, m_tvy, m_tax, m_tay, m_cww, m_sww;
  assign b_len = $signed({1'b0, a_pl_r.link_length});
  assign m_tvx = 68'(a_sw_r * b_len);
  assign m_tvy = 68'(a_cw_r * b_len);
  assign m_tax = 68'(a_sa_r * b_len);
  assign m_tay = 68'(a_ca_r * b_len);
  assign m_cww = 68'(a_cw_r * a_pl_r.link_omega);
  assign m_sww = 68'(a_sw_r * a_pl_r.link_omega);

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      b_r0_r  <= SW'(a_pl_r.base_pos_x) + SW'(a_px_r);
      b_r1_r  <= SW'(a_pl_r.base_pos_y) + SW'(a_py_r);
      b_tvx_r <= TW'(m_tvx >>> 16);
      b_tvy_r <= TW'(m_tvy >>> 16);
      b_tax_r <= TW'(m_tax >>> 16);
      b_tay_r <= TW'(m_tay >>> 16);
      b_cww_r <= TW'(m_cww >>> 16);
      b_sww_r <= TW'(m_sww >>> 16);
      b_pl_r  <= a_pl_r;
    end
  end

  logic [32:0]          cww_c, sww_c;
  logic signed [31:0]   c_len;
  logic signed [63:0]   m_tcx, m_tsx;
  assign cww_c = clip32(SW'(b_cww_r));
  assign sww_c = clip32(SW'(b_sww_r));
  assign c_len = $signed({1'b0, b_pl_r.link_length});
  assign m_tcx = $signed(cww_c[31:0]) * c_len;
  assign m_tsx = $signed(sww_c[31:0]) * c_len;

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      c_r0_r  <= b_r0_r;
      c_r1_r  <= b_r1_r;
      c_r2_r  <= SW'(b_pl_r.base_vel_x) - SW'(b_tvx_r);
      c_r3_r  <= SW'(b_pl_r.base_vel_y) + SW'(b_tvy_r);
      c_r4_r  <= SW'(b_pl_r.base_acc_x) - SW'(b_tax_r);
      c_r5_r  <= SW'(b_pl_r.base_acc_y) + SW'(b_tay_r);
      c_tcx_r <= 48'(m_tcx >>> 16);
      c_tsx_r <= 48'(m_tsx >>> 16);
      c_sat_r <= cww_c[32] | sww_c[32];
    end
  end

  logic [32:0] o0, o1, o2, o3, o4, o5;
  assign o0 = clip32(c_r0_r);
  assign o1 = clip32(c_r1_r);
  assign o2 = clip32(c_r2_r);
  assign o3 = clip32(c_r3_r);
  assign o4 = clip32(c_r4_r - SW'(c_tcx_r));
  assign o5 = clip32(c_r5_r - SW'(c_tsx_r));

  always_ff @(posedge clk) begin
    if (rdy_d) begin
      out_data_r.end_pos_x <= o0[31:0];
      out_data_r.end_pos_y <= o1[31:0];
      out_data_r.end_vel_x <= o2[31:0];
      out_data_r.end_vel_y <= o3[31:0];
      out_data_r.end_acc_x <= o4[31:0];
      out_data_r.end_acc_y <= o5[31:0];
      out_data_r.saturated <= c_sat_r | o0[32] | o1[32] | o2[32] | o3[32] | o4[32] | o5[32];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_c_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vc_r && !rdy_d |=> vc_r && $stable(c_r0_r))
    else $error("stage C lost a stalled transaction");
  a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
    vc_r && c_sat_r && rdy_d |=> out_data_r.saturated)
    else $error("centripetal clip not flagged");
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !va_r |-> rdy_a)
    else $error("empty stage A refused data");
`endif

endmodule

[sv/rlpk_cordic.sv]
// Pipelined angle reduction and CORDIC rotation producing cosine and sine in Q2.30.
module rlpk_cordic import rlpk_pkg::*; #(
  parameter int Steps = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [CW-1:0] out_cos,
  output logic signed [CW-1:0] out_sin,
  output in_t                  out_data
);

  localparam int D = Steps + 2;

  logic [D-1:0]         v_r;
  logic [D-1:0]         rdy;
  logic signed [CW-1:0] x_r [0:Steps];
  logic signed [CW-1:0] y_r [0:Steps];
  logic signed [CW-1:0] z_r [0:Steps];
  logic                 neg_r [0:Steps];
  in_t                  pl_r [0:Steps];
  logic signed [CW-1:0] c_r, s_r;
  in_t                  po_r;
  logic signed [CW-1:0] a0, a1, z0_nxt;
  logic                 neg0_nxt;

  assign rdy[D-1] = !v_r[D-1] || out_ready;
  for (genvar k = 0; k < D - 1; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end
  assign in_ready = rdy[0];

  always_comb begin
    a0 = CW'(in_data.link_angle);
    if (a0 > PI_Q28) begin
      a0 = a0 - TWO_PI_Q28;
    end else if (a0 < -PI_Q28) begin
      a0 = a0 + TWO_PI_Q28;
    end
    neg0_nxt = 1'b0;
    a1 = a0;
    if (a0 > HALF_PI_Q28) begin
      a1 = a0 - PI_Q28;
      neg0_nxt = 1'b1;
    end else if (a0 < -HALF_PI_Q28) begin
      a1 = a0 + PI_Q28;
      neg0_nxt = 1'b1;
    end
    z0_nxt = a1 <<< 2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      x_r[0]   <= CORDIC_GAIN;
      y_r[0]   <= '0;
      z_r[0]   <= z0_nxt;
      neg_r[0] <= neg0_nxt;
      pl_r[0]  <= in_data;
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic signed [CW-1:0] dx, dy, at;
    logic                 d;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    assign at = CW'($signed({1'b0, atan_val(5'(i))}));
    assign d  = !z_r[i][CW-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (rdy[i+1]) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i+1]) begin
        x_r[i+1]   <= d ? x_r[i] - dx : x_r[i] + dx;
        y_r[i+1]   <= d ? y_r[i] + dy : y_r[i] - dy;
        z_r[i+1]   <= d ? z_r[i] - at : z_r[i] + at;
        neg_r[i+1] <= neg_r[i];
        pl_r[i+1]  <= pl_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[D-1] <= 1'b0;
    end else if (rdy[D-1]) begin
      v_r[D-1] <= v_r[D-2];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[D-1]) begin
      c_r  <= neg_r[Steps] ? -x_r[Steps] : x_r[Steps];
      s_r  <= neg_r[Steps] ? -y_r[Steps] : y_r[Steps];
      po_r <= pl_r[Steps];
    end
  end

  assign out_valid = v_r[D-1];
  assign out_cos   = c_r;
  assign out_sin   = s_r;
  assign out_data  = po_r;

`ifndef SYNTHESIS
  a_z_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] |-> (z_r[0] <= Z_LIMIT && z_r[0] >= -Z_LIMIT))
    else $error("reduced angle out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[D-1] && !out_ready |=> v_r[D-1] && $stable(c_r) && $stable(s_r))
    else $error("stalled cordic result changed");
`endif

endmodule
